[rtl/pidc_pkg.sv]
package pidc_pkg;

  // field and register widths
  localparam int DATA_W      = 16;
  localparam int TS_W        = 16;
  localparam int LIMIT_W     = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;

  // fixed-point formats
  localparam int GAIN_FRAC   = 8;
  localparam int TS_FRAC     = 16;
  localparam int ACC_W       = 40;
  localparam int SUM_W       = 64;
  localparam int TERM_SH     = 61;
  localparam int MUL_A_W     = 2 * DATA_W + 1;

  // parameter defaults
  localparam int MEAS_WIDTH_DEF = 16;
  localparam int ACC_FRAC_DEF   = 16;

  localparam logic signed [SUM_W-1:0] TERM_LIM = 64'sd1 <<< TERM_SH;
  localparam logic signed [ACC_W-1:0] ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 3'd4;

  localparam logic signed [DATA_W-1:0] LOW_LIMIT_RST  = -16'sd400;
  localparam logic signed [DATA_W-1:0] HIGH_LIMIT_RST = 16'sd400;

  // request kinds
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // clamp side codes
  localparam logic [LIMIT_W-1:0] LIM_NONE = 2'd0;
  localparam logic [LIMIT_W-1:0] LIM_HIGH = 2'd1;
  localparam logic [LIMIT_W-1:0] LIM_LOW  = 2'd2;

endpackage

[rtl/pidc_div.sv]
module pidc_div #(
  parameter int NUM_W = 58,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  // two restoring steps per cycle, NUM_W must be even
  localparam int STEPS = NUM_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;

  always_comb begin
    rem_nxt = rem_r;
    num_nxt = num_r;
    trial   = '0;
    for (int k = 0; k < 2; k++) begin
      trial   = {rem_nxt, num_nxt[NUM_W-1]};
      num_nxt = {num_nxt[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        trial      = trial - {1'b0, den_r};
        num_nxt[0] = 1'b1;
      end
      rem_nxt = trial[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && (cnt_r == CNT_W'(1));
      if (start) begin
        cnt_r <= CNT_W'(STEPS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      num_r <= num;
      den_r <= den;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      num_r <= num_nxt;
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

[rtl/pid_controller_step_top.sv]
// pid step, derivative on measurement, one result per request
// an update makes four passes through the shared multiplier, then runs the derivative divider
//   (two quotient bits per cycle) unless the time step is zero, then the sums and the clamp
//   compare; a clear goes straight to the result; one request is in work at a time
// a result held by an out_tready stall also holds off the next request
// synchronous active-low reset: gains 0, limits -400/400, integral and last measurement 0
module pid_controller_step_top
  import pidc_pkg::*;
#(
  parameter int MEAS_WIDTH    = MEAS_WIDTH_DEF,
  parameter int ACC_FRAC_BITS = ACC_FRAC_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // target[15:0], measured[31:16], time_step[47:32]
  input  logic                   in_tuser,   // op[0]
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // drive[15:0], limit_hit[17:16], zero[23:18]
  // configuration write port
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DATA_W-1:0]      cfg_wdata
);

  // multiplier b operand holds an error, a measurement delta or a time step
  localparam int MB    = (MEAS_WIDTH + 1 > TS_W + 1) ? MEAS_WIDTH + 1 : TS_W + 1;
  localparam int PW    = MUL_A_W + MB;
  // magnitude of kd * delta
  localparam int MAGW  = MEAS_WIDTH + DATA_W + 1;
  // shifts that bring each term to ACC_FRAC_BITS fraction bits
  localparam int PSH   = ACC_FRAC_BITS - GAIN_FRAC;
  localparam int ISH   = GAIN_FRAC + TS_FRAC - ACC_FRAC_BITS;
  localparam int DSH   = ACC_FRAC_BITS + GAIN_FRAC;
  // divider dividend, padded to an even width
  localparam int ND    = MAGW + DSH;
  localparam int NDP   = ND + (ND % 2);
  localparam int QX    = (NDP > SUM_W) ? NDP : SUM_W;
  localparam int ACC_X = ACC_W + 1;
  localparam logic signed [SUM_W-1:0] PLIM = 64'sd1 <<< (TERM_SH - PSH);

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MKT  = 4'd1;   // ki * dt
  localparam logic [3:0] S_MKE  = 4'd2;   // (ki * dt) * err
  localparam logic [3:0] S_MKP  = 4'd3;   // kp * err, clamp increment
  localparam logic [3:0] S_MKD  = 4'd4;   // kd * delta, update integral
  localparam logic [3:0] S_DST  = 4'd5;   // launch divider
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_SUM1 = 4'd7;
  localparam logic [3:0] S_SUM2 = 4'd8;
  localparam logic [3:0] S_CMP  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0] state_r, state_nxt;

  // configuration
  logic signed [DATA_W-1:0] kp_r, ki_r, kd_r, lo_lim_r, hi_lim_r;

  // controller state
  logic signed [ACC_W-1:0]      acc_r;
  logic signed [MEAS_WIDTH-1:0] last_r;

  // request in work
  logic signed [MEAS_WIDTH-1:0] meas_r;
  logic [TS_W-1:0]              ts_r;
  logic signed [MB-1:0]         err_r, dlt_r;
  logic signed [PW-1:0]         mul_r;
  logic signed [ACC_W-1:0]      inc_r;
  logic signed [SUM_W-1:0]      pterm_r, dterm_r, sum_r;
  logic                         dneg_r;
  logic signed [DATA_W-1:0]     res_drive_r;
  logic [LIMIT_W-1:0]           res_flag_r;

  // output register
  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  // input field decode
  logic signed [MEAS_WIDTH-1:0] tgt_x, meas_x;
  logic [TS_W-1:0]              ts_in;
  logic                         in_acc;

  // shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MB-1:0]      mul_b;
  logic signed [PW-1:0]      mul_p;

  // datapath
  logic signed [PW-1:0]    inc_sh;
  logic signed [ACC_W-1:0] inc_c, acc_c;
  logic signed [ACC_X-1:0] acc_sum;
  logic signed [SUM_W-1:0] p64, pterm_c;
  logic signed [PW-1:0]    mag_full;
  logic [NDP-1:0]          div_num;
  logic                    div_start, div_done;
  logic [NDP-1:0]          div_quo;
  logic [QX-1:0]           qx;
  logic                    dsat;
  logic signed [SUM_W-1:0] dmag, dterm_c;
  logic signed [SUM_W-1:0] hi_c, lo_c, drive_sh;
  logic                    out_free;

  // measurement fields: low MEAS_WIDTH bits of the 16 bit field, or the field zero-extended when MEAS_WIDTH is wider
  generate
    if (MEAS_WIDTH <= DATA_W) begin : g_meas_narrow
      assign tgt_x  = in_tdata[MEAS_WIDTH-1:0];
      assign meas_x = in_tdata[DATA_W +: MEAS_WIDTH];
    end else begin : g_meas_wide
      assign tgt_x  = MEAS_WIDTH'(in_tdata[DATA_W-1:0]);
      assign meas_x = MEAS_WIDTH'(in_tdata[DATA_W +: DATA_W]);
    end
  endgenerate

  assign ts_in     = in_tdata[2*DATA_W +: TS_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  // operand select for the one multiplier, product registered in mul_r
  always_comb begin
    case (state_r)
      S_MKT: begin
        mul_a = MUL_A_W'(ki_r);
        mul_b = MB'(signed'({1'b0, ts_r}));
      end
      S_MKE: begin
        mul_a = signed'(mul_r[MUL_A_W-1:0]);
        mul_b = err_r;
      end
      S_MKP: begin
        mul_a = MUL_A_W'(kp_r);
        mul_b = err_r;
      end
      S_MKD: begin
        mul_a = MUL_A_W'(kd_r);
        mul_b = dlt_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // integral increment, floor shift then clamp to the accumulator range
  assign inc_sh = mul_r >>> ISH;
  always_comb begin
    if (inc_sh > PW'(ACC_MAX)) begin
      inc_c = ACC_MAX;
    end else if (inc_sh < PW'(ACC_MIN)) begin
      inc_c = ACC_MIN;
    end else begin
      inc_c = inc_sh[ACC_W-1:0];
    end
  end

  // accumulator saturates after the add
  assign acc_sum = ACC_X'(acc_r) + ACC_X'(inc_r);
  always_comb begin
    if (acc_sum > ACC_X'(ACC_MAX)) begin
      acc_c = ACC_MAX;
    end else if (acc_sum < ACC_X'(ACC_MIN)) begin
      acc_c = ACC_MIN;
    end else begin
      acc_c = acc_sum[ACC_W-1:0];
    end
  end

  // proportional term scaled up with saturation at the term limit
  assign p64 = SUM_W'(mul_r);
  always_comb begin
    if (p64 >= PLIM) begin
      pterm_c = TERM_LIM;
    end else if (p64 <= -PLIM) begin
      pterm_c = -TERM_LIM;
    end else begin
      pterm_c = p64 <<< PSH;
    end
  end

  // derivative: |kd * delta| * 2^DSH / dt in one long division
  assign mag_full  = mul_r[PW-1] ? -mul_r : mul_r;
  assign div_num   = NDP'(mag_full[MAGW-1:0]) << DSH;
  assign div_start = (state_r == S_DST) && (ts_r != '0);

  pidc_div #(
    .NUM_W (NDP),
    .DEN_W (TS_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (ts_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // quotient at or above 2^61 means the integer part overflowed the term limit
  assign qx      = QX'(div_quo);
  assign dsat    = qx >= (QX'(1) << TERM_SH);
  assign dmag    = dsat ? TERM_LIM : SUM_W'(qx);
  assign dterm_c = dneg_r ? dmag : -dmag;

  // limits in accumulator format
  assign hi_c     = SUM_W'(hi_lim_r) <<< ACC_FRAC_BITS;
  assign lo_c     = SUM_W'(lo_lim_r) <<< ACC_FRAC_BITS;
  assign drive_sh = sum_r >>> ACC_FRAC_BITS;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_tuser == OP_CLEAR) ? S_DONE : S_MKT;
        end
      end
      S_MKT:  state_nxt = S_MKE;
      S_MKE:  state_nxt = S_MKP;
      S_MKP:  state_nxt = S_MKD;
      S_MKD:  state_nxt = S_DST;
      S_DST:  state_nxt = (ts_r != '0) ? S_DIV : S_SUM1;
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_SUM1;
        end
      end
      S_SUM1: state_nxt = S_SUM2;
      S_SUM2: state_nxt = S_CMP;
      S_CMP:  state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control, configuration and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      kp_r         <= '0;
      ki_r         <= '0;
      kd_r         <= '0;
      lo_lim_r     <= LOW_LIMIT_RST;
      hi_lim_r     <= HIGH_LIMIT_RST;
      acc_r        <= '0;
      last_r       <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr_en) begin
        case (cfg_index)
          REG_PROP_GAIN:  kp_r     <= cfg_wdata;
          REG_INTEG_GAIN: ki_r     <= cfg_wdata;
          REG_DERIV_GAIN: kd_r     <= cfg_wdata;
          REG_LOW_LIMIT:  lo_lim_r <= cfg_wdata;
          REG_HIGH_LIMIT: hi_lim_r <= cfg_wdata;
          default: ;
        endcase
      end

      // clear request zeroes the state at accept
      if (in_acc && (in_tuser == OP_CLEAR)) begin
        acc_r  <= '0;
        last_r <= '0;
      end

      if (state_r == S_MKD) begin
        acc_r <= acc_c;
      end

      // a clamp discards the integral, measurement kept either way
      if (state_r == S_CMP) begin
        if ((sum_r > hi_c) || (sum_r < lo_c)) begin
          acc_r <= '0;
        end
        last_r <= meas_r;
      end

      if ((state_r == S_DONE) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      meas_r      <= meas_x;
      ts_r        <= ts_in;
      err_r       <= MB'(tgt_x) - MB'(meas_x);
      dlt_r       <= MB'(meas_x) - MB'(last_r);
      res_drive_r <= '0;
      res_flag_r  <= LIM_NONE;
    end

    if ((state_r == S_MKT) || (state_r == S_MKE) ||
        (state_r == S_MKP) || (state_r == S_MKD)) begin
      mul_r <= mul_p;
    end

    if (state_r == S_MKP) begin
      inc_r <= inc_c;
    end

    if (state_r == S_MKD) begin
      pterm_r <= pterm_c;
    end

    // negative product gives a positive derivative term
    if (state_r == S_DST) begin
      dneg_r  <= mul_r[PW-1];
      dterm_r <= '0;
    end

    if ((state_r == S_DIV) && div_done) begin
      dterm_r <= dterm_c;
    end

    if (state_r == S_SUM1) begin
      sum_r <= pterm_r + SUM_W'(acc_r);
    end
    if (state_r == S_SUM2) begin
      sum_r <= sum_r + dterm_r;
    end

    // high side is tested first
    if (state_r == S_CMP) begin
      if (sum_r > hi_c) begin
        res_drive_r <= hi_lim_r;
        res_flag_r  <= LIM_HIGH;
      end else if (sum_r < lo_c) begin
        res_drive_r <= lo_lim_r;
        res_flag_r  <= LIM_LOW;
      end else begin
        res_drive_r <= drive_sh[DATA_W-1:0];
        res_flag_r  <= LIM_NONE;
      end
    end

    if ((state_r == S_DONE) && out_free) begin
      out_tdata_r <= OUT_TDATA_W'({res_flag_r, res_drive_r});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // a request is never taken while another is in work
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while busy");

  // divider only runs with a nonzero time step
  a_div_ts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (ts_r != '0))
    else $error("divider running with zero time step");

  // clamp side code is never the unused value
  a_flag_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[17:16] != 2'd3))
    else $error("bad limit_hit code");

  // a new result appears only out of the final state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside the final state");

endmodule
